// ----- rtl/pfrt_pkg.sv -----
// Shared types and codes for the packet filter rule table.
package pfrt_pkg;

  localparam int RULES_DEF = 64;

  // operation codes
  localparam logic [1:0] FN_CHECK  = 2'd0;
  localparam logic [1:0] FN_ADD    = 2'd1;
  localparam logic [1:0] FN_AUTO   = 2'd2;
  localparam logic [1:0] FN_REMOVE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [1:0]  PROTO_ANY = 2'd0;
  localparam logic [15:0] PORT_ANY  = 16'd0;
  localparam logic        ACT_ALLOW = 1'b0;
  localparam logic        ACT_BLOCK = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] dest_ip;
    logic [15:0] port;
    logic [1:0]  protocol;
    logic        action;
  } in_t;

  typedef struct packed {
    logic       verdict;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic        is_block;
    logic [15:0] port;
    logic [1:0]  proto;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic rotate;   // take right neighbor's entry
    logic compact;  // odd-even hole/live exchange
    logic phase;    // which pairs exchange this cycle
    logic append;   // write new rule at fill position
  } cell_cmd_t;

endpackage

// ----- rtl/pfrt_cell.sv -----
// One rule slot of the table; shifts, exchanges with neighbors or takes a new rule.
module pfrt_cell #(
  parameter int RULES = pfrt_pkg::RULES_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfrt_pkg::cell_cmd_t        cmd,
  input  logic [$clog2(RULES+1)-1:0] fill_cnt,
  input  pfrt_pkg::entry_t           wr_entry,
  input  pfrt_pkg::entry_t           from_left,
  input  pfrt_pkg::entry_t           from_right,
  output pfrt_pkg::entry_t           ent
);

  localparam int FW = $clog2(RULES + 1);
  localparam logic [FW-1:0] MY_IDX = FW'(IDX);
  localparam logic MY_PAR = 1'(IDX % 2);

  pfrt_pkg::entry_t ent_r;
  pfrt_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.rotate) begin
      ent_nxt = from_right;
    end else if (cmd.compact) begin
      if (cmd.phase == MY_PAR) begin
        // left member of the pair: pull a live rule into a hole
        if (!ent_r.valid && from_right.valid) begin
          ent_nxt = from_right;
        end
      end else begin
        // right member: hand the rule over, become the hole
        // (cell 0 has no left partner and keeps its rule)
        if ((IDX != 0) && ent_r.valid && !from_left.valid) begin
          ent_nxt.valid = 1'b0;
        end
      end
    end else if (cmd.append && (fill_cnt == MY_IDX)) begin
      ent_nxt = wr_entry;
    end
    // only the valid bit is cleared by reset
    if (!rst_n) begin
      ent_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ----- rtl/pfrt_ctrl.sv -----
// Sequencer: handshakes, head-of-chain rule evaluation, fill count and result register.
module pfrt_ctrl #(
  parameter int RULES = pfrt_pkg::RULES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pfrt_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pfrt_pkg::out_t             out_data,
  input  pfrt_pkg::entry_t           head,
  output pfrt_pkg::entry_t           feed,
  output pfrt_pkg::cell_cmd_t        cmd,
  output logic [$clog2(RULES+1)-1:0] fill_cnt,
  output pfrt_pkg::entry_t           wr_entry
);

  localparam int FW = $clog2(RULES + 1);
  localparam int CW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(RULES - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(RULES);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_COMPACT = 4'b0100,
    S_RESULT  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  pfrt_pkg::in_t   op_r, op_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [FW-1:0]   del_r, del_nxt;
  logic            hit_r, hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  pfrt_pkg::out_t  out_r, out_nxt;

  logic            addr_eq;
  logic            pkt_match;
  logic            cnt_last;
  logic            full;
  logic            load;
  logic            do_append;
  pfrt_pkg::out_t  res;

  assign addr_eq   = head.valid && (head.address == op_r.dest_ip);
  assign pkt_match = addr_eq
                  && ((head.port == op_r.port) || (head.port == pfrt_pkg::PORT_ANY))
                  && ((head.proto == op_r.protocol) || (head.proto == pfrt_pkg::PROTO_ANY));
  assign cnt_last  = (cnt_r == CNT_LAST);
  assign full      = (fill_r == FILL_MAX);
  assign load      = (state_r == S_RESULT) && (!out_valid_r || !out_stall);

  // result of the finished operation
  always_comb begin
    res.verdict = 1'b0;
    res.status  = pfrt_pkg::ST_OK;
    do_append   = 1'b0;
    unique case (op_r.func)
      pfrt_pkg::FN_CHECK: begin
        if (op_r.protocol == pfrt_pkg::PROTO_ANY) begin
          res.verdict = 1'b1;
          res.status  = pfrt_pkg::ST_INVALID;
        end else begin
          res.verdict = hit_r;
        end
      end
      pfrt_pkg::FN_ADD: begin
        res.status = full ? pfrt_pkg::ST_FULL : pfrt_pkg::ST_OK;
        do_append  = !full;
      end
      pfrt_pkg::FN_AUTO: begin
        if (hit_r) begin
          res.status = pfrt_pkg::ST_BLOCKED;
        end else if (full) begin
          res.status = pfrt_pkg::ST_FULL;
        end else begin
          do_append = 1'b1;
        end
      end
      default: begin
        res.status = pfrt_pkg::ST_OK;
      end
    endcase
  end

  // new rule: add takes the item fields, auto block stores a block-any rule
  always_comb begin
    wr_entry.valid   = 1'b1;
    wr_entry.address = op_r.dest_ip;
    if (op_r.func == pfrt_pkg::FN_AUTO) begin
      wr_entry.is_block = pfrt_pkg::ACT_BLOCK;
      wr_entry.port     = pfrt_pkg::PORT_ANY;
      wr_entry.proto    = pfrt_pkg::PROTO_ANY;
    end else begin
      wr_entry.is_block = op_r.action;
      wr_entry.port     = op_r.port;
      wr_entry.proto    = op_r.protocol;
    end
  end

  // head entry wraps around to the tail; removed rules come back as holes
  always_comb begin
    feed = '0;
    if (state_r == S_SCAN) begin
      feed = head;
      if ((op_r.func == pfrt_pkg::FN_REMOVE) && addr_eq) begin
        feed.valid = 1'b0;
      end
    end
  end

  assign cmd.rotate  = (state_r == S_SCAN);
  assign cmd.compact = (state_r == S_COMPACT);
  assign cmd.phase   = cnt_r[0];
  assign cmd.append  = load && do_append;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    del_nxt   = del_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data;
          cnt_nxt = '0;
          del_nxt = '0;
          hit_nxt = 1'b0;
          if ((in_data.func == pfrt_pkg::FN_ADD) ||
              ((in_data.func == pfrt_pkg::FN_CHECK) &&
               (in_data.protocol == pfrt_pkg::PROTO_ANY))) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        unique case (op_r.func)
          pfrt_pkg::FN_CHECK: begin
            if (pkt_match) begin
              hit_nxt = head.is_block;
            end
          end
          pfrt_pkg::FN_AUTO: begin
            if (addr_eq && (head.is_block == pfrt_pkg::ACT_BLOCK)) begin
              hit_nxt = 1'b1;
            end
          end
          pfrt_pkg::FN_REMOVE: begin
            if (addr_eq) begin
              del_nxt = del_r + 1'b1;
            end
          end
          default: begin
            hit_nxt = hit_r;
          end
        endcase
        if (cnt_last) begin
          cnt_nxt = '0;
          if (op_r.func == pfrt_pkg::FN_REMOVE) begin
            fill_nxt  = fill_r - del_nxt;
            state_nxt = S_COMPACT;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_COMPACT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load) begin
          state_nxt = S_IDLE;
          if (do_append) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt = out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      del_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      del_r       <= del_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fill_cnt  = fill_r;

endmodule

// ----- rtl/packet_filter_rule_table_top.sv -----
// Top level of the packet filter rule table: a ring of rule cells and its sequencer.
//
// Input channel in_valid/in_stall/in_data carries one operation per transaction:
// check packet, add rule, auto block address or remove address rules. The result
// channel out_valid/out_stall/out_data returns exactly one verdict/status per
// operation, in order. A transaction moves when valid is high and stall is low.
// Rules sit in a chain of RULES cells. Check, auto block and remove rotate the
// whole chain once, one cell per cycle, and a single evaluator looks at the entry
// leaving cell 0; remove then runs odd-even exchanges between neighbor cells to
// close the gaps. Add, and check with protocol any, skip the rotation.
// One operation is in flight at a time; the next is accepted the cycle after the
// result enters the output register, so the rotation length sets the rate.
// A stalled result holds in the output register; the finished operation waits
// for it to drain before loading, and in_stall stays high meanwhile.
// Synchronous reset empties the table (all cells invalid, fill count zero).
module packet_filter_rule_table_top #(
  parameter int RULES = pfrt_pkg::RULES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pfrt_pkg::out_t out_data
);

  localparam int FW = $clog2(RULES + 1);

  pfrt_pkg::entry_t    ents [RULES];
  pfrt_pkg::entry_t    feed;
  pfrt_pkg::entry_t    wr_entry;
  pfrt_pkg::entry_t    no_entry;
  pfrt_pkg::cell_cmd_t cmd;
  logic [FW-1:0]       fill_cnt;

  assign no_entry = '0;

  pfrt_ctrl #(
    .RULES (RULES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (ents[0]),
    .feed      (feed),
    .cmd       (cmd),
    .fill_cnt  (fill_cnt),
    .wr_entry  (wr_entry)
  );

  for (genvar i = 0; i < RULES; i++) begin : g_cell
    pfrt_pkg::entry_t left_ent;
    pfrt_pkg::entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_ent = no_entry;
    end else begin : g_mid_l
      assign left_ent = ents[i-1];
    end

    // tail takes the wrapped head during rotation, a hole otherwise
    if (i == RULES - 1) begin : g_last
      assign right_ent = feed;
    end else begin : g_mid_r
      assign right_ent = ents[i+1];
    end

    pfrt_cell #(
      .RULES (RULES),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .fill_cnt   (fill_cnt),
      .wr_entry   (wr_entry),
      .from_left  (left_ent),
      .from_right (right_ent),
      .ent        (ents[i])
    );
  end

endmodule
